FILE: sv/dlwb_pkg.sv
// dlwb_pkg: shared codes, field widths and the brightness-to-duty table
// for the dual LED warning blink driver; no dependencies
`default_nettype none
package dlwb_pkg;

  localparam int unsigned TimeW   = 32;  // now_ms and time_left
  localparam int unsigned PeriodW = 13;  // blink period in ms
  localparam int unsigned SecW    = 17;  // warning thresholds
  localparam int unsigned DutyW   = 10;
  localparam int unsigned StepW   = 4;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 24;

  // item kinds carried on in_tuser
  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_SET_ONE   = 2'd1,
    FUNC_SET_BOTH  = 2'd2,
    FUNC_COUNTDOWN = 2'd3
  } func_t;

  // manual LED modes, code 3 is stored but acts as off
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;

  // register indexes on the config port
  localparam logic [CfgAddrW-1:0] REG_AUTO_WARN    = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_WARN_SEC     = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_WARN_FAST    = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_ACTIVE_LOW   = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_ALT_ENABLE   = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_BLINK_PERIOD = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_BRIGHTNESS   = 3'd6;

  localparam logic [PeriodW-1:0] SLOW_PERIOD = 13'd500;
  localparam logic [PeriodW-1:0] FAST_PERIOD = 13'd150;
  localparam logic [DutyW-1:0]   FULL_DUTY   = 10'd1023;
  localparam logic [DutyW:0]     LAST_DUTY_INIT = 11'd2047;

  // round(step^2 * 220 / 225), with full scale at the top step
  function automatic logic [DutyW-1:0] level_duty(input logic [StepW-1:0] step);
    logic [DutyW-1:0] d;
    case (step)
      4'd0:    d = 10'd0;
      4'd1:    d = 10'd1;
      4'd2:    d = 10'd4;
      4'd3:    d = 10'd9;
      4'd4:    d = 10'd16;
      4'd5:    d = 10'd24;
      4'd6:    d = 10'd35;
      4'd7:    d = 10'd48;
      4'd8:    d = 10'd63;
      4'd9:    d = 10'd79;
      4'd10:   d = 10'd98;
      4'd11:   d = 10'd118;
      4'd12:   d = 10'd141;
      4'd13:   d = 10'd165;
      4'd14:   d = 10'd192;
      default: d = FULL_DUTY;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: sv/dlwb_serial_mod.sv
// dlwb_serial_mod: bit-serial restoring remainder of a time value by a period
// one dividend bit per cycle; depends on dlwb_pkg
`default_nettype none
module dlwb_serial_mod (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [dlwb_pkg::TimeW-1:0]        dividend,
  input  wire logic [dlwb_pkg::PeriodW-1:0]      divisor,
  output logic                                   done,
  output logic [dlwb_pkg::PeriodW-1:0]           remainder
);

  localparam int unsigned CntW = $clog2(dlwb_pkg::TimeW);

  logic                          busy_r;
  logic                          done_r;
  logic [CntW-1:0]               cnt_r;
  logic [dlwb_pkg::TimeW-1:0]    dvd_r;
  logic [dlwb_pkg::PeriodW-1:0]  dsr_r;
  logic [dlwb_pkg::PeriodW-1:0]  rem_r;
  logic [dlwb_pkg::PeriodW-1:0]  rem_nxt;
  logic [dlwb_pkg::PeriodW:0]    trial;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[dlwb_pkg::TimeW-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = dlwb_pkg::PeriodW'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[dlwb_pkg::PeriodW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[dlwb_pkg::TimeW-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(dlwb_pkg::TimeW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

FILE: sv/dual_led_warning_blink_driver.sv
// dual_led_warning_blink_driver: top level, item decode, LED state, duty output
// depends on dlwb_pkg and dlwb_serial_mod
//
// usage:
//   input beats arrive on in_tvalid/in_tready with the item kind on in_tuser
//   (tick, set one LED, set both LEDs, countdown update). set and countdown
//   beats only update internal state. a tick beat yields exactly one output
//   beat holding both LED duties, their changed flags and the warning flags.
//   a tick runs the millisecond time through a bit-serial remainder unit, one
//   bit per cycle; the remainder passes through the S_OUT state into the output
//   register, and the next beat is taken right after the result is loaded there.
//   in_tready is low while a tick is in the divider or waiting for the output
//   register; the output register holds its beat while out_tready is low, and
//   a finished tick waits there until the held beat is taken.
//   the config port writes one register per cycle with cfg_we and is meant to
//   be used only while no tick is outstanding.
//   reset (rst_n low, synchronous) returns all registers to their defaults,
//   both LEDs to off, clears the warning override and marks both last duties
//   invalid so the first tick reports a change on each LED; in_tready stays
//   low while rst_n is low.
`default_nettype none
module dual_led_warning_blink_driver (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // config port
  input  wire logic                               cfg_we,
  input  wire logic [dlwb_pkg::CfgAddrW-1:0]      cfg_addr,
  input  wire logic [dlwb_pkg::CfgW-1:0]          cfg_wdata,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [dlwb_pkg::InDataW-1:0]       in_tdata,  // led_index, led_state[2],
                                                              // time_left[32], now_ms[32]
  input  wire logic [1:0]                         in_tuser,  // func
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [dlwb_pkg::OutDataW-1:0]           out_tdata  // first_duty[10], first_changed,
                                                              // second_duty[10], second_changed,
                                                              // warning_active, warning_fast
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic                            auto_warn_r;
  logic [dlwb_pkg::SecW-1:0]       warn_sec_r;
  logic [dlwb_pkg::SecW-1:0]       warn_fast_sec_r;
  logic                            active_low_r;
  logic                            alt_en_r;
  logic [dlwb_pkg::PeriodW-1:0]    blink_period_r;
  logic [dlwb_pkg::StepW-1:0]      bright_step_r;

  // LED state
  logic [1:0]                      mode_r [2];
  logic                            ovr_on_r;
  logic                            ovr_steady_r;
  logic                            ovr_fast_r;
  logic                            alt_cancel_r;
  logic [dlwb_pkg::DutyW:0]        last_duty_r [2];
  logic [dlwb_pkg::PeriodW-1:0]    period_r;

  logic                            out_valid_r;
  logic [dlwb_pkg::OutDataW-1:0]   out_data_r;

  // input fields
  dlwb_pkg::func_t                 in_func;
  logic                            in_led_index;
  logic [1:0]                      in_led_state;
  logic [dlwb_pkg::TimeW-1:0]      in_time_left;
  logic [dlwb_pkg::TimeW-1:0]      in_now_ms;
  logic                            in_fire;

  assign in_func      = dlwb_pkg::func_t'(in_tuser);
  assign in_led_index = in_tdata[0];
  assign in_led_state = in_tdata[2:1];
  assign in_time_left = in_tdata[34:3];
  assign in_now_ms    = in_tdata[66:35];
  assign in_fire      = in_tvalid && in_tready;

  // countdown window decode
  logic cd_in_window;
  logic cd_zero;
  logic cd_fast;
  assign cd_in_window = auto_warn_r && !in_time_left[dlwb_pkg::TimeW-1] &&
                        (in_time_left[dlwb_pkg::TimeW-2:0] <=
                         (dlwb_pkg::TimeW-1)'(warn_sec_r));
  assign cd_zero = (in_time_left == '0);
  assign cd_fast = (in_time_left[dlwb_pkg::TimeW-2:0] <=
                    (dlwb_pkg::TimeW-1)'(warn_fast_sec_r));

  // period used by this tick: override forces 500 or 150 ms on both LEDs
  logic [dlwb_pkg::PeriodW-1:0] tick_period;
  assign tick_period = ovr_on_r ? (ovr_fast_r ? dlwb_pkg::FAST_PERIOD
                                              : dlwb_pkg::SLOW_PERIOD)
                                : blink_period_r;

  logic                          div_start;
  logic                          div_done;
  logic [dlwb_pkg::PeriodW-1:0]  div_rem;

  assign div_start = in_fire && (in_func == dlwb_pkg::FUNC_TICK);

  dlwb_serial_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_now_ms),
    .divisor   (tick_period),
    .done      (div_done),
    .remainder (div_rem)
  );

  // duty computation once the remainder is in
  logic                          phase0, phase1;
  logic [1:0]                    eff_mode [2];
  logic                          lit [2];
  logic [dlwb_pkg::DutyW-1:0]    duty [2];
  logic [dlwb_pkg::DutyW-1:0]    level;
  logic                          changed [2];
  logic                          out_free;

  assign level  = dlwb_pkg::level_duty(bright_step_r);
  assign phase0 = (period_r != '0) &&
                  (div_rem < {1'b0, period_r[dlwb_pkg::PeriodW-1:1]});
  assign phase1 = phase0 ^ (alt_en_r && !alt_cancel_r);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (ovr_on_r) begin
        eff_mode[i] = ovr_steady_r ? dlwb_pkg::MODE_ON : dlwb_pkg::MODE_BLINK;
      end else begin
        eff_mode[i] = mode_r[i];
      end
    end
    lit[0] = (eff_mode[0] == dlwb_pkg::MODE_ON) ||
             ((eff_mode[0] == dlwb_pkg::MODE_BLINK) && phase0);
    lit[1] = (eff_mode[1] == dlwb_pkg::MODE_ON) ||
             ((eff_mode[1] == dlwb_pkg::MODE_BLINK) && phase1);
    for (int i = 0; i < 2; i++) begin
      duty[i] = lit[i] ? level : '0;
      // inverting a 10-bit duty is full scale minus duty
      if (active_low_r) duty[i] = ~duty[i];
      changed[i] = ({1'b0, duty[i]} != last_duty_r[i]);
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (div_start) state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      auto_warn_r     <= 1'b0;
      warn_sec_r      <= 17'd300;
      warn_fast_sec_r <= 17'd60;
      active_low_r    <= 1'b0;
      alt_en_r        <= 1'b0;
      blink_period_r  <= 13'd1000;
      bright_step_r   <= 4'd15;
      mode_r[0]       <= dlwb_pkg::MODE_OFF;
      mode_r[1]       <= dlwb_pkg::MODE_OFF;
      ovr_on_r        <= 1'b0;
      ovr_steady_r    <= 1'b0;
      ovr_fast_r      <= 1'b0;
      alt_cancel_r    <= 1'b0;
      last_duty_r[0]  <= dlwb_pkg::LAST_DUTY_INIT;
      last_duty_r[1]  <= dlwb_pkg::LAST_DUTY_INIT;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_we) begin
        unique case (cfg_addr)
          dlwb_pkg::REG_AUTO_WARN:    auto_warn_r     <= cfg_wdata[0];
          dlwb_pkg::REG_WARN_SEC:     warn_sec_r      <= cfg_wdata[dlwb_pkg::SecW-1:0];
          dlwb_pkg::REG_WARN_FAST:    warn_fast_sec_r <= cfg_wdata[dlwb_pkg::SecW-1:0];
          dlwb_pkg::REG_ACTIVE_LOW:   active_low_r    <= cfg_wdata[0];
          dlwb_pkg::REG_ALT_ENABLE: begin
            alt_en_r     <= cfg_wdata[0];
            alt_cancel_r <= 1'b0;
          end
          dlwb_pkg::REG_BLINK_PERIOD: blink_period_r  <= cfg_wdata[dlwb_pkg::PeriodW-1:0];
          dlwb_pkg::REG_BRIGHTNESS:   bright_step_r   <= cfg_wdata[dlwb_pkg::StepW-1:0];
          default: ;
        endcase
      end

      // state-only items
      if (in_fire) begin
        unique case (in_func)
          dlwb_pkg::FUNC_SET_ONE: begin
            mode_r[in_led_index] <= in_led_state;
            if (in_led_state != dlwb_pkg::MODE_BLINK) alt_cancel_r <= 1'b1;
          end
          dlwb_pkg::FUNC_SET_BOTH: begin
            mode_r[0] <= in_led_state;
            mode_r[1] <= in_led_state;
            if (in_led_state != dlwb_pkg::MODE_BLINK) alt_cancel_r <= 1'b1;
          end
          dlwb_pkg::FUNC_COUNTDOWN: begin
            ovr_on_r <= cd_in_window;
            // steady/fast flags keep their old values outside the window
            if (cd_in_window) begin
              ovr_steady_r <= cd_zero;
              ovr_fast_r   <= !cd_zero && cd_fast;
            end
          end
          dlwb_pkg::FUNC_TICK: period_r <= tick_period;
          default: ;
        endcase
      end

      // load the result beat, or drop the one just taken
      if (state_r == S_OUT && out_free) begin
        out_valid_r    <= 1'b1;
        out_data_r     <= {ovr_on_r && !ovr_steady_r && ovr_fast_r, ovr_on_r,
                           changed[1], duty[1], changed[0], duty[0]};
        last_duty_r[0] <= {1'b0, duty[0]};
        last_duty_r[1] <= {1'b0, duty[1]};
      end else if (out_tready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

FILE: sv/dlwb_checker.sv
// dlwb_checker: port-level checks for the dual LED warning blink driver
// depends on dlwb_pkg; bound to the top level at the end of this file
`default_nettype none
module dlwb_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic [1:0]                         in_tuser,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [dlwb_pkg::OutDataW-1:0]      out_tdata
);

  // reset leaves no result beat behind
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat present after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // fast warning only reported with the override in force
  a_fast_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[23] && !out_tdata[22]))
    else $error("warning_fast without warning_active");

  // a tick keeps the input side busy while the remainder is worked out
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == dlwb_pkg::FUNC_TICK) |=> !in_tready)
    else $error("input accepted while a tick is in progress");

endmodule

bind dual_led_warning_blink_driver dlwb_checker u_dlwb_checker (.*);
`default_nettype wire
